>>> src/dsae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsae_pkg
// Action codes, status codes, sequencer states and defaults for the
// dual-stack ALU engine.
// ----------------------------------------------------------------------------
package dsae_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int CELL_WIDTH_DEF  = 64;

  localparam int ACTION_W  = 5;
  localparam int LITERAL_W = 64;
  localparam int TOP_W     = 64;
  localparam int COUNT_W   = 9;
  localparam int STATUS_W  = 3;

  localparam int S_TDATA_W = 72;  // 69 bits of fields, padded to whole bytes
  localparam int M_TDATA_W = 88;  // 85 bits of fields, padded to whole bytes

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH        = 5'd0,
    ACT_ADD         = 5'd1,
    ACT_SUB         = 5'd2,
    ACT_MUL         = 5'd3,
    ACT_DIV         = 5'd4,
    ACT_MOD         = 5'd5,
    ACT_SHL         = 5'd6,
    ACT_SHR         = 5'd7,
    ACT_OR          = 5'd8,
    ACT_XOR         = 5'd9,
    ACT_AND         = 5'd10,
    ACT_BNOT        = 5'd11,
    ACT_NOT         = 5'd12,
    ACT_EQ          = 5'd13,
    ACT_NE          = 5'd14,
    ACT_GT          = 5'd15,
    ACT_LT          = 5'd16,
    ACT_GE          = 5'd17,
    ACT_LE          = 5'd18,
    ACT_DROP        = 5'd19,
    ACT_SWAP        = 5'd20,
    ACT_TO_R        = 5'd21,
    ACT_FROM_R      = 5'd22,
    ACT_COPY_TO_R   = 5'd23,
    ACT_COPY_FROM_R = 5'd24,
    ACT_RDROP       = 5'd25,
    ACT_RESET       = 5'd26
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_DATA_UNDER = 3'd1,
    ST_DATA_OVER  = 3'd2,
    ST_RET_UNDER  = 3'd3,
    ST_RET_OVER   = 3'd4,
    ST_DIV_ZERO   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_BUSY   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

endpackage
`default_nettype wire

>>> src/dual_stack_alu_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_stack_alu_engine
// Forth-style data and return stacks in two synchronous memories, with the
// primitive stack and ALU actions applied by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  s_*       in    s_tvalid / s_tready  action, literal
//  m_*       out   m_tvalid / m_tready  top_value, data_count, return_count, status
//
//  Per word: most actions read the memory at accept, then execute and write
//  back; swap writes two data entries through the single write port; mul
//  forms three partial products on one half-width multiplier; div and mod
//  produce one quotient bit a cycle. Reset clears the two depth counters,
//  the output valid and the sequencer state; stack entries above the depth
//  are never used, so there is no clearing pass. While the result register
//  is full and not taken, the final write-back holds and no new word is taken.
// ----------------------------------------------------------------------------
module dual_stack_alu_engine #(
  parameter int STACK_DEPTH = dsae_pkg::STACK_DEPTH_DEF,
  parameter int CELL_WIDTH  = dsae_pkg::CELL_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [4:0] action, [68:5] literal, [71:69] zero
  input  wire logic [dsae_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [63:0] top_value, [72:64] data_count, [81:73] return_count, [84:82] status
  output logic      [dsae_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int DW   = $clog2(STACK_DEPTH + 1);
  localparam int SW   = $clog2(CELL_WIDTH);
  localparam int HALF = (CELL_WIDTH + 1) / 2;
  localparam int CNTW = $clog2(CELL_WIDTH);

  typedef logic [CELL_WIDTH-1:0] cell_t;

  // stack memories
  cell_t dmem [STACK_DEPTH];
  cell_t rmem [STACK_DEPTH];

  dsae_pkg::state_t  state;
  dsae_pkg::action_t op;
  cell_t             lit;
  cell_t             rd_a;   // second data entry
  cell_t             rd_b;   // top data entry
  cell_t             rd_r;   // top return entry
  logic [DW-1:0]     dep;
  logic [DW-1:0]     rdep;

  // long-op unit
  logic [CNTW-1:0]   cnt;
  logic [2*HALF-1:0] acc;
  cell_t             quo;
  cell_t             rem;

  logic              in_fire;
  logic              out_free;
  logic              fire;
  logic              long_go;
  logic              swap_go;
  logic              unit_done;
  logic              dmem_we;
  logic              rmem_we;

  logic [DW-1:0]     d_m1;
  logic [DW-1:0]     d_m2;
  logic [DW-1:0]     r_m1;

  dsae_pkg::status_t status;
  logic              ok;
  cell_t             alu;
  cell_t             res;
  cell_t             unit_res;
  logic              dwe;
  logic              rwe;
  logic [AW-1:0]     dwaddr;
  logic [AW-1:0]     rwaddr;
  cell_t             dwdata;
  cell_t             rwdata;
  logic [DW-1:0]     dep_next;
  logic [DW-1:0]     rdep_next;
  cell_t             top_next;

  logic [2*HALF-1:0] ext_a;
  logic [2*HALF-1:0] ext_b;
  logic [HALF-1:0]   mul_x;
  logic [HALF-1:0]   mul_y;
  logic [2*HALF-1:0] prod;
  logic [CELL_WIDTH:0] div_sh;
  logic [CELL_WIDTH:0] div_diff;

  assign s_tready = (state == dsae_pkg::S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign d_m1 = dep - DW'(1);
  assign d_m2 = dep - DW'(2);
  assign r_m1 = rdep - DW'(1);

  // status and next state of the stacks for the held word
  always_comb begin
    status = dsae_pkg::ST_OK;
    case (op)
      dsae_pkg::ACT_PUSH: begin
        if (dep >= DW'(STACK_DEPTH)) status = dsae_pkg::ST_DATA_OVER;
      end
      dsae_pkg::ACT_ADD, dsae_pkg::ACT_SUB, dsae_pkg::ACT_MUL, dsae_pkg::ACT_SHL,
      dsae_pkg::ACT_SHR, dsae_pkg::ACT_OR, dsae_pkg::ACT_XOR, dsae_pkg::ACT_AND,
      dsae_pkg::ACT_EQ, dsae_pkg::ACT_NE, dsae_pkg::ACT_GT, dsae_pkg::ACT_LT,
      dsae_pkg::ACT_GE, dsae_pkg::ACT_LE, dsae_pkg::ACT_SWAP: begin
        if (dep < DW'(2)) status = dsae_pkg::ST_DATA_UNDER;
      end
      dsae_pkg::ACT_DIV, dsae_pkg::ACT_MOD: begin
        if (dep < DW'(2)) status = dsae_pkg::ST_DATA_UNDER;
        else if (rd_b == '0) status = dsae_pkg::ST_DIV_ZERO;
      end
      dsae_pkg::ACT_BNOT, dsae_pkg::ACT_NOT, dsae_pkg::ACT_DROP: begin
        if (dep == '0) status = dsae_pkg::ST_DATA_UNDER;
      end
      dsae_pkg::ACT_TO_R, dsae_pkg::ACT_COPY_TO_R: begin
        if (dep == '0) status = dsae_pkg::ST_DATA_UNDER;
        else if (rdep >= DW'(STACK_DEPTH)) status = dsae_pkg::ST_RET_OVER;
      end
      dsae_pkg::ACT_FROM_R, dsae_pkg::ACT_COPY_FROM_R: begin
        if (rdep == '0) status = dsae_pkg::ST_RET_UNDER;
        else if (dep >= DW'(STACK_DEPTH)) status = dsae_pkg::ST_DATA_OVER;
      end
      dsae_pkg::ACT_RDROP: begin
        if (rdep == '0) status = dsae_pkg::ST_RET_UNDER;
      end
      default: ;
    endcase
    ok = (status == dsae_pkg::ST_OK);

    alu = '0;
    case (op)
      dsae_pkg::ACT_ADD:  alu = rd_a + rd_b;
      dsae_pkg::ACT_SUB:  alu = rd_a - rd_b;
      dsae_pkg::ACT_SHL:  alu = (rd_b >= CELL_WIDTH'(CELL_WIDTH)) ? '0 : (rd_a << rd_b[SW-1:0]);
      dsae_pkg::ACT_SHR:  alu = (rd_b >= CELL_WIDTH'(CELL_WIDTH)) ? '0 : (rd_a >> rd_b[SW-1:0]);
      dsae_pkg::ACT_OR:   alu = rd_a | rd_b;
      dsae_pkg::ACT_XOR:  alu = rd_a ^ rd_b;
      dsae_pkg::ACT_AND:  alu = rd_a & rd_b;
      dsae_pkg::ACT_BNOT: alu = ~rd_b;
      dsae_pkg::ACT_NOT:  alu = (rd_b == '0) ? '1 : '0;
      dsae_pkg::ACT_EQ:   alu = (rd_a == rd_b) ? '1 : '0;
      dsae_pkg::ACT_NE:   alu = (rd_a != rd_b) ? '1 : '0;
      dsae_pkg::ACT_GT:   alu = (rd_a > rd_b) ? '1 : '0;
      dsae_pkg::ACT_LT:   alu = (rd_a < rd_b) ? '1 : '0;
      dsae_pkg::ACT_GE:   alu = (rd_a >= rd_b) ? '1 : '0;
      dsae_pkg::ACT_LE:   alu = (rd_a <= rd_b) ? '1 : '0;
      default:            alu = '0;
    endcase
    res = (state == dsae_pkg::S_FINISH) ? unit_res : alu;

    dwe       = 1'b0;
    rwe       = 1'b0;
    dwaddr    = d_m1[AW-1:0];
    dwdata    = res;
    rwaddr    = rdep[AW-1:0];
    rwdata    = rd_b;
    dep_next  = dep;
    rdep_next = rdep;
    top_next  = (dep != '0) ? rd_b : '0;
    if (ok) begin
      case (op)
        dsae_pkg::ACT_PUSH: begin
          dwe      = 1'b1;
          dwaddr   = dep[AW-1:0];
          dwdata   = lit;
          dep_next = dep + DW'(1);
          top_next = lit;
        end
        dsae_pkg::ACT_ADD, dsae_pkg::ACT_SUB, dsae_pkg::ACT_MUL, dsae_pkg::ACT_DIV,
        dsae_pkg::ACT_MOD, dsae_pkg::ACT_SHL, dsae_pkg::ACT_SHR, dsae_pkg::ACT_OR,
        dsae_pkg::ACT_XOR, dsae_pkg::ACT_AND, dsae_pkg::ACT_EQ, dsae_pkg::ACT_NE,
        dsae_pkg::ACT_GT, dsae_pkg::ACT_LT, dsae_pkg::ACT_GE, dsae_pkg::ACT_LE: begin
          dwe      = 1'b1;
          dwaddr   = d_m2[AW-1:0];
          dep_next = d_m1;
          top_next = res;
        end
        dsae_pkg::ACT_BNOT, dsae_pkg::ACT_NOT: begin
          dwe      = 1'b1;
          top_next = res;
        end
        dsae_pkg::ACT_DROP: begin
          dep_next = d_m1;
          top_next = (d_m1 != '0) ? rd_a : '0;
        end
        dsae_pkg::ACT_SWAP: begin
          // first cycle writes the top slot, the finishing cycle the second
          dwe = 1'b1;
          if (state == dsae_pkg::S_EXEC) begin
            dwaddr = d_m1[AW-1:0];
            dwdata = rd_a;
          end else begin
            dwaddr = d_m2[AW-1:0];
            dwdata = rd_b;
          end
          top_next = rd_a;
        end
        dsae_pkg::ACT_TO_R, dsae_pkg::ACT_COPY_TO_R: begin
          rwe       = 1'b1;
          rdep_next = rdep + DW'(1);
          if (op == dsae_pkg::ACT_TO_R) begin
            dep_next = d_m1;
            top_next = (d_m1 != '0) ? rd_a : '0;
          end
        end
        dsae_pkg::ACT_FROM_R, dsae_pkg::ACT_COPY_FROM_R: begin
          dwe      = 1'b1;
          dwaddr   = dep[AW-1:0];
          dwdata   = rd_r;
          dep_next = dep + DW'(1);
          top_next = rd_r;
          if (op == dsae_pkg::ACT_FROM_R) rdep_next = r_m1;
        end
        dsae_pkg::ACT_RDROP: rdep_next = r_m1;
        dsae_pkg::ACT_RESET: begin
          dep_next = '0;
          top_next = '0;
        end
        default: ;
      endcase
    end
  end

  assign long_go = (state == dsae_pkg::S_EXEC) && ok &&
                   (op inside {dsae_pkg::ACT_MUL, dsae_pkg::ACT_DIV, dsae_pkg::ACT_MOD});
  assign swap_go = (state == dsae_pkg::S_EXEC) && ok && (op == dsae_pkg::ACT_SWAP);
  assign fire    = out_free && ((state == dsae_pkg::S_FINISH) ||
                   ((state == dsae_pkg::S_EXEC) && !long_go && !swap_go));
  assign dmem_we = dwe && (fire || swap_go);
  assign rmem_we = rwe && fire;

  // half-width multiplier: low*low, low_a*high_b, high_a*low_b
  assign ext_a = (2*HALF)'(rd_a);
  assign ext_b = (2*HALF)'(rd_b);
  assign mul_x = (cnt == CNTW'(2)) ? ext_a[2*HALF-1:HALF] : ext_a[HALF-1:0];
  assign mul_y = (cnt == CNTW'(1)) ? ext_b[2*HALF-1:HALF] : ext_b[HALF-1:0];
  assign prod  = (2*HALF)'(mul_x) * (2*HALF)'(mul_y);

  // restoring divider step
  assign div_sh   = {rem, quo[CELL_WIDTH-1]};
  assign div_diff = div_sh - {1'b0, rd_b};

  assign unit_done = (op == dsae_pkg::ACT_MUL) ? (cnt == CNTW'(2))
                                               : (cnt == CNTW'(CELL_WIDTH - 1));
  assign unit_res  = (op == dsae_pkg::ACT_MUL) ? acc[CELL_WIDTH-1:0] :
                     (op == dsae_pkg::ACT_DIV) ? quo : rem;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dsae_pkg::S_IDLE;
      dep      <= '0;
      rdep     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        dsae_pkg::S_IDLE: begin
          if (in_fire) state <= dsae_pkg::S_EXEC;
        end
        dsae_pkg::S_EXEC: begin
          if (long_go) state <= dsae_pkg::S_BUSY;
          else if (swap_go) state <= dsae_pkg::S_FINISH;
          else if (fire) state <= dsae_pkg::S_IDLE;
        end
        dsae_pkg::S_BUSY: begin
          if (unit_done) state <= dsae_pkg::S_FINISH;
        end
        dsae_pkg::S_FINISH: begin
          if (fire) state <= dsae_pkg::S_IDLE;
        end
        default: state <= dsae_pkg::S_IDLE;
      endcase
      if (fire) begin
        dep      <= dep_next;
        rdep     <= rdep_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload, operands and the long-op unit
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op  <= dsae_pkg::action_t'(s_tdata[dsae_pkg::ACTION_W-1:0]);
      lit <= CELL_WIDTH'(s_tdata[dsae_pkg::ACTION_W +: dsae_pkg::LITERAL_W]);
    end
    if (fire) begin
      m_tdata <= {3'b000, 3'(status), dsae_pkg::COUNT_W'(rdep_next),
                  dsae_pkg::COUNT_W'(dep_next), dsae_pkg::TOP_W'(top_next)};
    end
    if (long_go) begin
      cnt <= '0;
      acc <= '0;
      quo <= rd_a;
      rem <= '0;
    end else if (state == dsae_pkg::S_BUSY) begin
      cnt <= cnt + CNTW'(1);
      if (op == dsae_pkg::ACT_MUL) begin
        acc <= acc + ((cnt == '0) ? prod : {prod[HALF-1:0], {HALF{1'b0}}});
      end else begin
        rem <= div_diff[CELL_WIDTH] ? div_sh[CELL_WIDTH-1:0] : div_diff[CELL_WIDTH-1:0];
        quo <= {quo[CELL_WIDTH-2:0], !div_diff[CELL_WIDTH]};
      end
    end
  end

  // stack memories: read at accept, write back during execution
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_b <= dmem[d_m1[AW-1:0]];
      rd_a <= dmem[d_m2[AW-1:0]];
    end
    if (dmem_we) dmem[dwaddr] <= dwdata;
  end

  always_ff @(posedge clk) begin
    if (in_fire) rd_r <= rmem[r_m1[AW-1:0]];
    if (rmem_we) rmem[rwaddr] <= rwdata;
  end

  // reads and writes of the stacks never share an edge
  a_no_rw_overlap : assert property (@(posedge clk) disable iff (rst)
    !(in_fire && (dmem_we || rmem_we)))
    else $error("stack read and write at the same edge");

  // a refused action leaves both depths unchanged
  a_refused_holds : assert property (@(posedge clk) disable iff (rst)
    (fire && !ok) |=> (dep == $past(dep) && rdep == $past(rdep)))
    else $error("refused action changed a stack depth");

  // depths stay within the stack size
  a_depth_bound : assert property (@(posedge clk) disable iff (rst)
    fire |=> (dep <= DW'(STACK_DEPTH) && rdep <= DW'(STACK_DEPTH)))
    else $error("stack depth beyond its size");

endmodule
`default_nettype wire
